FILE: rtl/core/afu_pkg.sv
// shared constants, codes, control struct and rom builder for the activation unit
// no dependencies; used by scoped names in afu_rom, afu_datapath and the top
package afu_pkg;

	localparam int D_ONE = 4096;
	localparam int TBL_N = 257;
	localparam int VAL_W = 16;

	localparam logic [1:0] KIND_LINEAR  = 2'd0;
	localparam logic [1:0] KIND_SIGMOID = 2'd1;
	localparam logic [1:0] KIND_TANH    = 2'd2;

	localparam logic REQ_FWD  = 1'b0;
	localparam logic REQ_GRAD = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic       req;
	} op_ctrl_t;

	typedef logic [TBL_N*VAL_W-1:0] rom_t;

	// elaboration-time unsigned quotient by shift and subtract
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem    = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// elaboration-time table build: e^(-1/16) in q62 by series, then its powers
	function automatic rom_t build_rom(input logic tanh_sel);
		logic [63:0]  pw [0:256];
		logic [63:0]  term;
		logic [63:0]  e16;
		logic [63:0]  y;
		logic [63:0]  y2;
		logic [63:0]  num;
		logic [63:0]  den;
		logic [63:0]  q;
		logic [63:0]  q40;
		logic [127:0] prod;
		logic [15:0]  t;
		rom_t         rom;
		int           d;
		int           m;
		q40  = 64'd1 << 40;
		term = 64'd1 << 62;
		e16  = term;
		rom  = '0;
		for (int n = 1; n <= 16; n++) begin
			term = udiv64(term, 64'(16 * n));
			if ((n & 1) == 1) begin
				e16 = e16 - term;
			end else begin
				e16 = e16 + term;
			end
		end
		pw[0] = 64'd1 << 62;
		for (int n = 1; n <= 256; n++) begin
			prod  = {64'd0, pw[n-1]} * {64'd0, e16};
			pw[n] = prod[125:62];
		end
		for (int k = 0; k < TBL_N; k++) begin
			d  = k - 128;
			m  = (d < 0) ? -d : d;
			y  = (pw[m] + (64'd1 << 21)) >> 22;
			y2 = (pw[2*m] + (64'd1 << 21)) >> 22;
			if (tanh_sel) begin
				num = q40 - y2;
				den = q40 + y2;
			end else begin
				num = (d >= 0) ? q40 : y;
				den = q40 + y;
			end
			q = udiv64(num * 64'd8192 + den, 64'd2 * den);
			t = q[15:0];
			if (tanh_sel && (d < 0)) begin
				t = -t;
			end
			rom[k*VAL_W +: VAL_W] = t;
		end
		return rom;
	endfunction

	localparam rom_t SIG_ROM  = build_rom(1'b0);
	localparam rom_t TANH_ROM = build_rom(1'b1);

endpackage

FILE: rtl/core/afu_rom.sv
// constant sigmoid / tanh tables, two adjacent entries read per cycle
// depends on afu_pkg
module afu_rom (
	input  logic                            tanh_sel,
	input  logic [7:0]                      index,
	output logic signed [afu_pkg::VAL_W-1:0] lo,
	output logic signed [afu_pkg::VAL_W-1:0] hi
);

	logic [8:0] idx_lo;
	logic [8:0] idx_hi;

	assign idx_lo = {1'b0, index};
	assign idx_hi = idx_lo + 9'd1;

	always_comb begin
		if (tanh_sel) begin
			lo = afu_pkg::TANH_ROM[idx_lo*afu_pkg::VAL_W +: afu_pkg::VAL_W];
			hi = afu_pkg::TANH_ROM[idx_hi*afu_pkg::VAL_W +: afu_pkg::VAL_W];
		end else begin
			lo = afu_pkg::SIG_ROM[idx_lo*afu_pkg::VAL_W +: afu_pkg::VAL_W];
			hi = afu_pkg::SIG_ROM[idx_hi*afu_pkg::VAL_W +: afu_pkg::VAL_W];
		end
	end

endmodule

FILE: rtl/core/afu_datapath.sv
// single-pass activation / gradient arithmetic around one shared multiplier
// depends on afu_pkg and afu_rom
module afu_datapath (
	input  afu_pkg::op_ctrl_t                ctrl,
	input  logic signed [afu_pkg::VAL_W-1:0] operand,
	output logic signed [afu_pkg::VAL_W-1:0] result
);

	logic [15:0]        offset;
	logic signed [15:0] rom_lo;
	logic signed [15:0] rom_hi;
	logic signed [17:0] op_ext;
	logic signed [17:0] delta;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] prod;
	logic signed [36:0] wide;

	// offset binary: top byte picks the segment, low byte interpolates
	assign offset = operand ^ 16'h8000;
	assign op_ext = 18'(operand);
	assign delta  = 18'(rom_hi) - 18'(rom_lo);

	afu_rom u_rom (
		.tanh_sel (ctrl.kind == afu_pkg::KIND_TANH),
		.index    (offset[15:8]),
		.lo       (rom_lo),
		.hi       (rom_hi)
	);

	always_comb begin
		if (ctrl.req == afu_pkg::REQ_FWD) begin
			mul_a = delta;
			mul_b = {10'd0, offset[7:0]};
		end else if (ctrl.kind == afu_pkg::KIND_SIGMOID) begin
			mul_a = op_ext;
			mul_b = 18'sd4096 - op_ext;
		end else begin
			mul_a = op_ext;
			mul_b = op_ext;
		end
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		case (ctrl.kind)
			afu_pkg::KIND_SIGMOID, afu_pkg::KIND_TANH: begin
				if (ctrl.req == afu_pkg::REQ_FWD) begin
					wide = 37'(rom_lo) + 37'(prod >>> 8);
				end else if (ctrl.kind == afu_pkg::KIND_SIGMOID) begin
					wide = 37'(prod >>> 12);
				end else begin
					wide = 37'(afu_pkg::D_ONE) - 37'(prod >>> 12);
				end
			end
			default: begin
				// linear and the unused code
				if (ctrl.req == afu_pkg::REQ_FWD) begin
					wide = 37'(operand);
				end else begin
					wide = 37'(afu_pkg::D_ONE);
				end
			end
		endcase
	end

	// saturate to the signed 16 bit range
	always_comb begin
		if (wide > 37'sd32767) begin
			result = 16'sh7fff;
		end else if (wide < -37'sd32768) begin
			result = 16'sh8000;
		end else begin
			result = wide[15:0];
		end
	end

endmodule

FILE: rtl/core/activation_function_unit_top.sv
// activation unit top: config register, input register, datapath, result register
// depends on afu_pkg and afu_datapath
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+---------------------------
//  input   | in_valid, in_stall, req_type, operand_in,  | in_valid && !in_stall
//          | last_in                                   |
//  output  | out_valid, out_stall, value_out, last_out | out_valid && !out_stall
//  config  | cfg_we, cfg_wdata                         | cfg_we
//
//  one item per cycle sustained while out_stall is low; an accepted item passes
//  the input register, then the result register, before out_valid rises for it
//  the rate is set by the single pass through rom, shared multiplier and saturation
//  between the input register and the result register
//  arst_n clears the valid flags and sets kind_q to linear
//  a stalled result holds; the input register keeps filling until both stages are full,
//  then in_stall follows out_stall
module activation_function_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic signed [15:0] operand_in,
	input  logic        last_in,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [15:0] value_out,
	output logic        last_out
);

	logic [1:0]         kind_q;

	// input register
	logic               valid_s1;
	logic               req_s1;
	logic signed [15:0] operand_s1;
	logic               last_s1;

	// result register
	logic               valid_s2;
	logic signed [15:0] value_s2;
	logic               last_s2;

	logic               advance;
	logic               load_s1;
	afu_pkg::op_ctrl_t  ctrl;
	logic signed [15:0] result;

	// result stage moves when empty or taken; input stage refills behind it
	assign advance  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || advance;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= afu_pkg::KIND_LINEAR;
		end else if (cfg_we) begin
			kind_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			req_s1     <= req_type;
			operand_s1 <= operand_in;
			last_s1    <= last_in;
		end
	end

	assign ctrl.kind = kind_q;
	assign ctrl.req  = req_s1;

	afu_datapath u_dp (
		.ctrl    (ctrl),
		.operand (operand_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			value_s2 <= result;
			last_s2  <= last_s1;
		end
	end

	assign out_valid = valid_s2;
	assign value_out = value_s2;
	assign last_out  = last_s2;

endmodule

FILE: rtl/core/afu_checker.sv
// port-level checks for the activation unit, attached by bind
// depends on activation_function_unit_top ports only
module afu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        req_type,
	input logic signed [15:0] operand_in,
	input logic        last_in,
	input logic        out_valid,
	input logic        out_stall,
	input logic signed [15:0] value_out,
	input logic        last_out
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(last_out))
		else $error("stalled result changed");

	// a stalled input transfer holds its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(req_type) && $stable(operand_in)
			&& $stable(last_in))
		else $error("stalled input changed");

	// input only backs up when the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// accepted item reaches out_valid through the input and result registers when output is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted item did not reach output");

	// no result without an earlier input transfer through the input and result registers
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without input transfer");

endmodule

bind activation_function_unit_top afu_checker u_afu_checker (.*);
